### hw/rtl/randomized_exponential_backoff_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the randomized exponential back-off block
// Same-cycle and next-cycle implication checks with a synchronous reset guard.
// ----------------------------------------------------------------------------
`ifndef RANDOMIZED_EXPONENTIAL_BACKOFF_DEFINES_SVH
`define RANDOMIZED_EXPONENTIAL_BACKOFF_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define REXB_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("Same-cycle check failed in %m.");

// The consequent must hold in the cycle after the antecedent.
`define REXB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("Next-cycle check failed in %m.");

`endif

### hw/rtl/rexb_pkg.sv
// ----------------------------------------------------------------------------
// rexb_pkg
// Shared types and constants of the randomized exponential back-off block.
// ----------------------------------------------------------------------------
package rexb_pkg;

    localparam int unsigned IVAL_W   = 32;
    localparam int unsigned JIT_W    = 9;
    localparam int unsigned GROW_W   = 16;
    localparam int unsigned RND_W    = 16;
    localparam int unsigned CMD_W    = 2;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 32;
    localparam int unsigned MUL_A_W  = IVAL_W + 1;
    localparam int unsigned MUL_B_W  = 17;
    localparam int unsigned PROD_W   = MUL_A_W + MUL_B_W;

    localparam logic [IVAL_W-1:0] RST_INITIAL  = 32'd500;
    localparam logic [IVAL_W-1:0] RST_CEILING  = 32'd60000;
    localparam logic [IVAL_W-1:0] RST_LIMIT    = 32'd900000;
    localparam logic [JIT_W-1:0]  RST_JITTER   = 9'd128;
    localparam logic [GROW_W-1:0] RST_GROWTH   = 16'd384;
    localparam logic [JIT_W-1:0]  JITTER_ONE   = 9'd256;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK    = 2'd0,
        CMD_NEXT    = 2'd1,
        CMD_RESTART = 2'd2
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INITIAL = 3'd0,
        CFG_CEILING = 3'd1,
        CFG_LIMIT   = 3'd2,
        CFG_JITTER  = 3'd3,
        CFG_GROWTH  = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MUL_LO   = 2'd0,
        MUL_HI   = 2'd1,
        MUL_OFF  = 2'd2,
        MUL_GROW = 2'd3
    } t_mul_sel;

    typedef struct packed {
        logic     tick;
        logic     restart;
        logic     capture;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     ld_lo;
        logic     ld_span;
        logic     ld_delay;
        logic     ld_out;
        logic     out_stop;
        logic     upd_ival;
    } t_dp_cmd;

    typedef struct packed {
        logic stop_hit;
    } t_dp_status;

endpackage

### hw/rtl/rexb_ctrl.sv
// ----------------------------------------------------------------------------
// rexb_ctrl
// Sequencer that steps the shared multiplier through the delay and growth
// products and manages the input and output handshakes.
// ----------------------------------------------------------------------------
module rexb_ctrl
    import rexb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic [CMD_W-1:0]     i_command,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  t_dp_status           i_status,
    output t_dp_cmd              o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LO,
        S_HI,
        S_SPAN,
        S_OFF,
        S_GROW,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_stop, n_stop;
    logic   r_out_valid, n_out_valid;
    logic   w_accept;
    logic   w_slot_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign w_slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_stop      = r_stop;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.mul_sel = MUL_LO;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_command == CMD_TICK) begin
                        o_cmd.tick = 1'b1;
                    end else if (i_command == CMD_RESTART) begin
                        o_cmd.restart = 1'b1;
                    end else if (i_command == CMD_NEXT) begin
                        o_cmd.capture = 1'b1;
                        n_stop  = i_status.stop_hit;
                        n_state = i_status.stop_hit ? S_DONE : S_LO;
                    end
                end
            end
            S_LO: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_LO;
                n_state = S_HI;
            end
            S_HI: begin
                o_cmd.ld_lo   = 1'b1;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_HI;
                n_state = S_SPAN;
            end
            S_SPAN: begin
                o_cmd.ld_span = 1'b1;
                n_state = S_OFF;
            end
            S_OFF: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_OFF;
                n_state = S_GROW;
            end
            S_GROW: begin
                o_cmd.ld_delay = 1'b1;
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_sel  = MUL_GROW;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_slot_free) begin
                    o_cmd.ld_out   = 1'b1;
                    o_cmd.out_stop = r_stop;
                    o_cmd.upd_ival = !r_stop;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_stop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_stop      <= n_stop;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### hw/rtl/rexb_dp.sv
// ----------------------------------------------------------------------------
// rexb_dp
// Configuration registers, interval and elapsed state, the shared multiplier
// and the output register of the back-off block.
// ----------------------------------------------------------------------------
module rexb_dp
    import rexb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  logic [RND_W-1:0]     i_random,
    input  t_dp_cmd              i_cmd,
    output t_dp_status           o_status,
    output logic [IVAL_W-1:0]    o_delay,
    output logic                 o_stop
);

    logic [IVAL_W-1:0]  r_initial;
    logic [IVAL_W-1:0]  r_ceiling;
    logic [IVAL_W-1:0]  r_limit;
    logic [JIT_W-1:0]   r_jitter;
    logic [GROW_W-1:0]  r_growth;
    logic [IVAL_W-1:0]  r_ival;
    logic [IVAL_W-1:0]  r_elapsed;

    logic [RND_W-1:0]   r_rnd;
    logic [PROD_W-1:0]  r_prod;
    logic [MUL_A_W-1:0] r_lo;
    logic [MUL_A_W-1:0] r_span;
    logic [IVAL_W-1:0]  r_delay;
    logic [IVAL_W-1:0]  r_out_delay;
    logic               r_out_stop;

    logic [JIT_W-1:0]   w_jit;
    logic [MUL_A_W-1:0] w_mul_a;
    logic [MUL_B_W-1:0] w_mul_b;
    logic [MUL_A_W:0]   w_sum;
    logic [IVAL_W-1:0]  w_sum_sat;
    logic [IVAL_W+7:0]  w_grown;
    logic [IVAL_W-1:0]  w_grown_sat;
    logic [IVAL_W-1:0]  w_next_ival;

    assign w_jit = (r_jitter > JITTER_ONE) ? JITTER_ONE : r_jitter;

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_LO: begin
                w_mul_a = {1'b0, r_ival};
                w_mul_b = MUL_B_W'(JITTER_ONE - w_jit);
            end
            MUL_HI: begin
                w_mul_a = {1'b0, r_ival};
                w_mul_b = MUL_B_W'({1'b0, JITTER_ONE} + {1'b0, w_jit});
            end
            MUL_OFF: begin
                w_mul_a = r_span;
                w_mul_b = MUL_B_W'(r_rnd);
            end
            default: begin
                w_mul_a = {1'b0, r_ival};
                w_mul_b = MUL_B_W'(r_growth);
            end
        endcase
    end

    assign w_sum       = {1'b0, r_lo} + {1'b0, r_prod[RND_W +: MUL_A_W]};
    assign w_sum_sat   = (|w_sum[MUL_A_W:IVAL_W]) ? '1 : w_sum[IVAL_W-1:0];
    assign w_grown     = r_prod[8 +: IVAL_W+8];
    assign w_grown_sat = (|w_grown[IVAL_W+7:IVAL_W]) ? '1 : w_grown[IVAL_W-1:0];
    assign w_next_ival = (w_grown_sat > r_ceiling) ? r_ceiling : w_grown_sat;

    assign o_status.stop_hit = (r_elapsed >= r_limit);
    assign o_delay = r_out_delay;
    assign o_stop  = r_out_stop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_initial <= RST_INITIAL;
            r_ceiling <= RST_CEILING;
            r_limit   <= RST_LIMIT;
            r_jitter  <= RST_JITTER;
            r_growth  <= RST_GROWTH;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_INITIAL: r_initial <= i_cfg_data;
                CFG_CEILING: r_ceiling <= i_cfg_data;
                CFG_LIMIT:   r_limit   <= i_cfg_data;
                CFG_JITTER:  r_jitter  <= i_cfg_data[JIT_W-1:0];
                CFG_GROWTH:  r_growth  <= i_cfg_data[GROW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ival    <= RST_INITIAL;
            r_elapsed <= '0;
        end else begin
            if (i_cmd.restart) begin
                r_ival    <= r_initial;
                r_elapsed <= '0;
            end else if (i_cmd.upd_ival) begin
                r_ival <= w_next_ival;
            end
            if (i_cmd.tick && (r_elapsed != '1)) begin
                r_elapsed <= r_elapsed + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_rnd <= i_random;
        end
        if (i_cmd.mul_en) begin
            r_prod <= w_mul_a * w_mul_b;
        end
        if (i_cmd.ld_lo) begin
            r_lo <= r_prod[8 +: MUL_A_W];
        end
        if (i_cmd.ld_span) begin
            r_span <= r_prod[8 +: MUL_A_W] - r_lo;
        end
        if (i_cmd.ld_delay) begin
            r_delay <= w_sum_sat;
        end
        if (i_cmd.ld_out) begin
            r_out_delay <= i_cmd.out_stop ? '0 : r_delay;
            r_out_stop  <= i_cmd.out_stop;
        end
    end

endmodule

### hw/rtl/randomized_exponential_backoff.sv
// ----------------------------------------------------------------------------
// randomized_exponential_backoff
// Exponential back-off delay generator with uniform jitter and a stop limit.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tuser command, tdata random
// m_axis    out        m_axis_tvalid / m_axis_tready  tdata delay, tuser stop
// cfg       in         i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
// Tick and restart items are taken in the idle state. A next item steps
// through the shared 33 x 17 multiplier (four products), or skips it when it stops.
// Synchronous reset restores the configuration registers, the interval and the elapsed count.
// A finished result waits in its step until the output register is free.
// Configuration writes are always taken.
// ----------------------------------------------------------------------------
`include "randomized_exponential_backoff_defines.svh"

module randomized_exponential_backoff
    import rexb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [15:0]          s_axis_tdata,   // [15:0] random_fraction
    input  logic [1:0]           s_axis_tuser,   // [1:0] command
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [31:0]          m_axis_tdata,   // [31:0] delay
    output logic                 m_axis_tuser,   // [0] stop
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic       w_in_take;
    logic       w_take_next;
    logic       w_take_other;

    assign o_cfg_ready = 1'b1;

    rexb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_command   (s_axis_tuser),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    rexb_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_random    (s_axis_tdata),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_delay     (m_axis_tdata),
        .o_stop      (m_axis_tuser)
    );

    assign w_in_take    = s_axis_tvalid && s_axis_tready;
    assign w_take_next  = w_in_take && (s_axis_tuser == CMD_NEXT);
    assign w_take_other = w_in_take && (s_axis_tuser == CMD_TICK || s_axis_tuser == CMD_RESTART);

    `REXB_ASSERT_NEXT(a_next_busy, i_clk, i_rst_n, w_take_next, !s_axis_tready)
    `REXB_ASSERT_NEXT(a_tick_idle, i_clk, i_rst_n, w_take_other, s_axis_tready)
    `REXB_ASSERT_SAME(a_stop_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0)

endmodule

### sim/randomized_exponential_backoff_test.sv
// ----------------------------------------------------------------------------
// randomized_exponential_backoff_test
// Self-checking bench for the back-off delay generator. A scoreboard class
// tracks the interval, the elapsed count and the registers, predicts every
// delay or stop answer, and compares each output item with the oldest one
// predicted. A short directed run covers the saturating and stopping corners.
// Random phases follow, each with its own register setting, and idle either
// stream at random unless that phase holds the stream steady.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

import rexb_pkg::*;

typedef struct packed {
    logic [31:0] delay;
    logic        stop;
} t_backoff_result;

class delay_scoreboard;
    logic [31:0]     start_ival;
    logic [31:0]     ceiling;
    logic [31:0]     limit;
    logic [8:0]      jitter;
    logic [15:0]     growth;
    logic [31:0]     cur_ival;
    logic [31:0]     elapsed;
    t_backoff_result due_results[$];
    int              errors;
    int              n_items;
    int              n_results;
    int              n_stops;

    function new();
        start_ival = RST_INITIAL;
        ceiling    = RST_CEILING;
        limit      = RST_LIMIT;
        jitter     = RST_JITTER;
        growth     = RST_GROWTH;
        cur_ival   = RST_INITIAL;
        elapsed    = '0;
    endfunction

    function void write_reg(t_cfg_idx idx, logic [31:0] val);
        case (idx)
            CFG_INITIAL: start_ival = val;
            CFG_CEILING: ceiling    = val;
            CFG_LIMIT:   limit      = val;
            CFG_JITTER:  jitter     = val[8:0];
            CFG_GROWTH:  growth     = val[15:0];
            default: ;
        endcase
    endfunction

    function int pending();
        return due_results.size();
    endfunction

    function void apply_command(logic [1:0] cmd, logic [15:0] frac);
        logic [63:0]     f;
        logic [63:0]     lo;
        logic [63:0]     hi;
        logic [63:0]     off;
        logic [63:0]     sum;
        logic [63:0]     grown;
        t_backoff_result r;
        n_items++;
        case (cmd)
            CMD_TICK: begin
                if (elapsed != 32'hFFFF_FFFF) elapsed++;
            end
            CMD_RESTART: begin
                cur_ival = start_ival;
                elapsed  = '0;
            end
            CMD_NEXT: begin
                if (elapsed >= limit) begin
                    r.delay = '0;
                    r.stop  = 1'b1;
                end else begin
                    f   = (jitter > JITTER_ONE) ? 64'd256 : {55'd0, jitter};
                    lo  = ({32'd0, cur_ival} * (64'd256 - f)) >> 8;
                    hi  = ({32'd0, cur_ival} * (64'd256 + f)) >> 8;
                    off = ((hi - lo) * {48'd0, frac}) >> 16;
                    sum = lo + off;
                    r.delay = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
                    r.stop  = 1'b0;
                    grown = ({32'd0, cur_ival} * {48'd0, growth}) >> 8;
                    if (grown > 64'hFFFF_FFFF) grown = 64'hFFFF_FFFF;
                    cur_ival = (grown[31:0] > ceiling) ? ceiling : grown[31:0];
                end
                due_results.push_back(r);
            end
            default: ;
        endcase
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        if (errors <= 40)
            $display("%0t: %s wrong on result %0d: got %h, expected %h",
                     $time, what, n_results, got, want);
    endtask

    task check_delay(logic [31:0] delay, logic stop);
        t_backoff_result want;
        n_results++;
        if (stop) n_stops++;
        if (due_results.size() == 0) begin
            report_mismatch("unexpected item", delay, '0);
            return;
        end
        want = due_results.pop_front();
        if (delay !== want.delay) report_mismatch("delay", delay, want.delay);
        if (stop !== want.stop) report_mismatch("stop", {31'd0, stop}, {31'd0, want.stop});
    endtask
endclass

module randomized_exponential_backoff_test;

    localparam int CLK_PERIOD    = 8;
    localparam int LIMIT_CYCLES  = 2_000_000;
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_PHASES = 14;
    localparam int PHASE_ITEMS   = 115;
    localparam int HOLD_CYCLES   = 400;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [15:0]          s_axis_tdata;   // [15:0] random_fraction
    logic [1:0]           s_axis_tuser;   // [1:0] command
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [31:0]          m_axis_tdata;   // [31:0] delay
    logic                 m_axis_tuser;   // [0] stop
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    delay_scoreboard board = new();
    bit src_steady  = 1'b0;
    bit sink_steady = 1'b0;
    bit hold_req    = 1'b0;
    int settings    = 0;

    randomized_exponential_backoff uut (.*);

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("timeout with %0d results outstanding", board.pending());
        $display("end of test: mismatches");
        $finish;
    end

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 40) return 0;
        else if (p < 85) return $urandom_range(1, 3);
        else if (p < 97) return $urandom_range(4, 12);
        else return $urandom_range(20, 60);
    endfunction

    // Output side: random stalls, plus one long hold-off on request.
    initial begin
        int stall_left;
        stall_left = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
                if (!sink_steady && $urandom_range(0, 99) < 30) stall_left = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_delay(m_axis_tdata, m_axis_tuser);
    end

    task automatic send_item(logic [1:0] cmd, logic [15:0] frac);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= frac;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        board.apply_command(cmd, frac);
        @(negedge i_clk);
        gap = src_steady ? 0 : pick_gap();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        board.write_reg(idx, val);
        @(negedge i_clk);
    endtask

    task automatic configure(logic [31:0] ival, logic [31:0] ceil, logic [31:0] lim,
                             logic [31:0] jit, logic [31:0] grow);
        write_reg(CFG_INITIAL, ival);
        write_reg(CFG_CEILING, ceil);
        write_reg(CFG_LIMIT, lim);
        write_reg(CFG_JITTER, jit);
        write_reg(CFG_GROWTH, grow);
        i_cfg_valid <= 1'b0;
        settings++;
    endtask

    // Waits until every predicted item has come back and the block is quiet.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic random_settings();
        logic [31:0] ival;
        logic [31:0] ceil;
        logic [31:0] lim;
        logic [31:0] jit;
        logic [31:0] grow;
        case ($urandom_range(0, 9))
            0: ival = '0;
            1: ival = '1;
            2, 3: ival = $urandom;
            default: ival = $urandom_range(1, 2000);
        endcase
        case ($urandom_range(0, 7))
            0: ceil = '0;
            1: ceil = '1;
            2, 3: ceil = $urandom;
            default: ceil = $urandom_range(1, 200000);
        endcase
        case ($urandom_range(0, 9))
            0: lim = '0;
            1: lim = '1;
            2: lim = $urandom;
            default: lim = $urandom_range(1, 40);
        endcase
        case ($urandom_range(0, 7))
            0: jit = 0;
            1: jit = 256;
            2: jit = $urandom_range(257, 511);
            default: jit = $urandom_range(1, 255);
        endcase
        case ($urandom_range(0, 7))
            0: grow = 0;
            1: grow = 32'h0000_FFFF;
            2: grow = $urandom_range(0, 65535);
            default: grow = $urandom_range(200, 800);
        endcase
        jit  = ($urandom & ~32'h0000_01FF) | jit;
        grow = ($urandom & ~32'h0000_FFFF) | grow;
        configure(ival, ceil, lim, jit, grow);
    endtask

    task automatic directed_run();
        send_item(CMD_NEXT, 16'h0000);
        send_item(CMD_NEXT, 16'hFFFF);
        send_item(CMD_TICK, 16'h5A5A);
        send_item(CMD_NEXT, 16'h8000);
        send_item(CMD_UNUSED, 16'hFFFF);
        send_item(CMD_RESTART, 16'h1234);
        send_item(CMD_NEXT, 16'hFFFF);
        settle();
        configure('1, '1, '1, 32'd256, 32'h0000_FFFF);
        send_item(CMD_RESTART, 16'h0000);
        send_item(CMD_NEXT, 16'hFFFF);
        send_item(CMD_NEXT, 16'h0000);
        settle();
        configure(32'd1000, 32'd0, 32'd100, 32'h0000_01FF, 32'd0);
        send_item(CMD_RESTART, 16'h0000);
        send_item(CMD_NEXT, 16'hFFFF);
        send_item(CMD_NEXT, 16'hFFFF);
        settle();
        configure(32'd0, 32'd50, 32'd2, 32'd128, 32'd512);
        send_item(CMD_RESTART, 16'h0000);
        send_item(CMD_NEXT, 16'hFFFF);
        send_item(CMD_TICK, 16'h0000);
        send_item(CMD_TICK, 16'h0000);
        send_item(CMD_NEXT, 16'hFFFF);
        settle();
        configure(32'd7, 32'd100, 32'd0, 32'd64, 32'd384);
        send_item(CMD_RESTART, 16'h0000);
        send_item(CMD_NEXT, 16'h7FFF);
        send_item(CMD_TICK, 16'h0000);
        send_item(CMD_NEXT, 16'h0001);
    endtask

    initial begin
        int          counted;
        int          p;
        logic [1:0]  cmd;
        logic [15:0] frac;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        directed_run();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            settle();
            random_settings();
            src_steady  = ($urandom_range(0, 3) == 0);
            sink_steady = ($urandom_range(0, 3) == 0);
            if (ph == 1) begin
                src_steady = 1'b1;
                hold_req   = 1'b1;
            end
            send_item(CMD_RESTART, 16'($urandom_range(0, 65535)));
            counted = 1;
            while (counted < PHASE_ITEMS) begin
                p = $urandom_range(0, 99);
                if (p < 7) cmd = CMD_RESTART;
                else if (p < 40) cmd = CMD_TICK;
                else if (p < 93) cmd = CMD_NEXT;
                else cmd = CMD_UNUSED;
                p = $urandom_range(0, 99);
                if (p < 5) frac = 16'h0000;
                else if (p < 10) frac = 16'hFFFF;
                else frac = 16'($urandom_range(0, 65535));
                send_item(cmd, frac);
                if (cmd != CMD_UNUSED) counted++;
            end
        end
        settle();

        $display("Ran %0d items over %0d register settings, with one long output hold-off.",
                 board.n_items, settings);
        $display("Checked %0d delay items, %0d of them stop answers.",
                 board.n_results, board.n_stops);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
